// ===== src/ubds_pkg.sv =====
// ----------------------------------------------------------------------------
// ubds_pkg
// Shared widths, constants and types for the UART baud divisor search.
// ----------------------------------------------------------------------------
package ubds_pkg;

	localparam int CLK_W     = 27;
	localparam int TGT_W     = 24;
	localparam int DIV_OUT_W = 13;
	localparam int OSR_OUT_W = 6;
	localparam int ERR_W     = 24;

	localparam logic [CLK_W-1:0] CLK_RESET = 27'd24000000;
	localparam logic [ERR_W-1:0] ERR_SAT   = 24'hFFFFFF;

	localparam int MAX_DIVISOR_DEF    = 8191;
	localparam int MIN_OVERSAMPLE_DEF = 4;
	localparam int MAX_OVERSAMPLE_DEF = 32;

	typedef struct packed {
		logic [DIV_OUT_W-1:0] best_divisor;
		logic [OSR_OUT_W-1:0] best_oversample;
		logic [ERR_W-1:0]     rate_error;
		logic                 found;
	} ubds_result_t;

endpackage

// ===== src/uart_baud_divisor_search.sv =====
// ----------------------------------------------------------------------------
// uart_baud_divisor_search
// Finds the UART divisor and oversampling ratio closest to a requested baud
// rate for the configured module clock.
//
//   channel | signals                         | direction
//   --------+---------------------------------+----------
//   in      | in_valid, in_ready, target_baud | in
//   out     | out_valid, out_ready, best_*,   | out
//           | rate_error, found               |
//   cfg     | cfg_we, cfg_wdata               | in
//
// A zero target skips the search and goes straight to the done state.
// Otherwise each ratio costs up to three divisions on the 27-step serial
// divider, one for the base divisor and one per candidate; a full search
// covers 29 ratios.
// One word is in flight at a time; in_ready is low while searching. The output
// register holds a result until taken and the next word is accepted meanwhile.
// Reset restores the clock register to 24 MHz.
// ----------------------------------------------------------------------------
module uart_baud_divisor_search
	import ubds_pkg::*;
#(
	parameter int MAX_DIVISOR    = MAX_DIVISOR_DEF,
	parameter int MIN_OVERSAMPLE = MIN_OVERSAMPLE_DEF,
	parameter int MAX_OVERSAMPLE = MAX_OVERSAMPLE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CLK_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [TGT_W-1:0]     target_baud,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DIV_OUT_W-1:0] best_divisor,
	output logic [OSR_OUT_W-1:0] best_oversample,
	output logic [ERR_W-1:0]     rate_error,
	output logic                 found
);

	logic [CLK_W-1:0] clock_hz_q;
	logic             out_valid_q;
	ubds_result_t     out_q;
	ubds_result_t     res;
	logic             res_valid;
	logic             res_ready;

	assign res_ready = !out_valid_q || out_ready;

	ubds_ctrl #(
		.MAX_DIVISOR    (MAX_DIVISOR),
		.MIN_OVERSAMPLE (MIN_OVERSAMPLE),
		.MAX_OVERSAMPLE (MAX_OVERSAMPLE)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.module_clock_hz (clock_hz_q),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.target_baud     (target_baud),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.res             (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_hz_q  <= CLK_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				clock_hz_q <= cfg_wdata;
			end
			if (res_ready) begin
				out_valid_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign best_divisor    = out_q.best_divisor;
	assign best_oversample = out_q.best_oversample;
	assign rate_error      = out_q.rate_error;
	assign found           = out_q.found;

endmodule

// ===== src/ubds_divider.sv =====
// ----------------------------------------------------------------------------
// ubds_divider
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ubds_divider #(
	parameter int DVD_W = 27,
	parameter int DVS_W = 30
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;

	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = !diff[DVS_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ===== src/ubds_ctrl.sv =====
// ----------------------------------------------------------------------------
// ubds_ctrl
// Search sequencer: walks the ratios, drives the shared multiplier and
// divider, and keeps the best divisor/ratio pair.
// ----------------------------------------------------------------------------
module ubds_ctrl
	import ubds_pkg::*;
#(
	parameter int MAX_DIVISOR    = MAX_DIVISOR_DEF,
	parameter int MIN_OVERSAMPLE = MIN_OVERSAMPLE_DEF,
	parameter int MAX_OVERSAMPLE = MAX_OVERSAMPLE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [CLK_W-1:0]   module_clock_hz,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [TGT_W-1:0]   target_baud,
	output logic               res_valid,
	input  logic               res_ready,
	output ubds_result_t       res
);

	localparam int RAT_W  = $clog2(MAX_OVERSAMPLE + 2);
	localparam int DIV_W  = $clog2(MAX_DIVISOR + 1);
	localparam int PROD_W = TGT_W + RAT_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_BASE,
		S_DIV_BASE,
		S_WAIT_BASE,
		S_CAND,
		S_MUL_ACH,
		S_DIV_ACH,
		S_WAIT_ACH,
		S_EVAL,
		S_NEXT,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [TGT_W-1:0]  target_q;
	logic [RAT_W-1:0]  ratio_q;
	logic              k_q;
	logic [CLK_W-1:0]  base_q;
	logic [DIV_W-1:0]  sbr_q;
	logic [PROD_W-1:0] prod_q;
	logic [CLK_W-1:0]  err_q;
	logic              found_q;
	logic [DIV_W-1:0]  best_sbr_q;
	logic [RAT_W-1:0]  best_ratio_q;
	logic [CLK_W-1:0]  best_err_q;

	logic [RAT_W-1:0]  rp1;
	logic [TGT_W-1:0]  mul_a;
	logic [PROD_W-1:0] product;
	logic [CLK_W:0]    cand;
	logic              cand_ok;
	logic              div_start;
	logic              div_done;
	logic [CLK_W-1:0]  div_q;
	logic [CLK_W-1:0]  tgt_ext;

	always_comb begin
		rp1     = ratio_q + 1'b1;
		mul_a   = (state_q == S_MUL_BASE) ? target_q : TGT_W'(sbr_q);
		product = PROD_W'(mul_a) * PROD_W'(rp1);
		cand    = {1'b0, base_q} + (CLK_W+1)'(k_q);
		cand_ok = (cand != '0) && (cand <= (CLK_W+1)'(MAX_DIVISOR));
		tgt_ext = CLK_W'(target_q);
		div_start = (state_q == S_DIV_BASE) || (state_q == S_DIV_ACH);
	end

	ubds_divider #(
		.DVD_W (CLK_W),
		.DVS_W (PROD_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (module_clock_hz),
		.divisor  (prod_q),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			found_q <= 1'b0;
			k_q     <= 1'b0;
			ratio_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						target_q <= target_baud;
						found_q  <= 1'b0;
						ratio_q  <= RAT_W'(MIN_OVERSAMPLE);
						state_q  <= (target_baud == '0) ? S_DONE : S_MUL_BASE;
					end
				end
				S_MUL_BASE: begin
					prod_q  <= product;
					state_q <= S_DIV_BASE;
				end
				S_DIV_BASE: begin
					state_q <= S_WAIT_BASE;
				end
				S_WAIT_BASE: begin
					if (div_done) begin
						base_q  <= div_q;
						k_q     <= 1'b0;
						state_q <= S_CAND;
					end
				end
				S_CAND: begin
					sbr_q   <= cand[DIV_W-1:0];
					state_q <= cand_ok ? S_MUL_ACH : S_NEXT;
				end
				S_MUL_ACH: begin
					prod_q  <= product;
					state_q <= S_DIV_ACH;
				end
				S_DIV_ACH: begin
					state_q <= S_WAIT_ACH;
				end
				S_WAIT_ACH: begin
					if (div_done) begin
						err_q   <= (div_q >= tgt_ext) ? div_q - tgt_ext : tgt_ext - div_q;
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (!found_q || err_q < best_err_q) begin
						found_q      <= 1'b1;
						best_err_q   <= err_q;
						best_sbr_q   <= sbr_q;
						best_ratio_q <= ratio_q;
					end
					state_q <= (err_q == '0) ? S_DONE : S_NEXT;
				end
				S_NEXT: begin
					if (!k_q) begin
						k_q     <= 1'b1;
						state_q <= S_CAND;
					end else if (ratio_q == RAT_W'(MAX_OVERSAMPLE)) begin
						state_q <= S_DONE;
					end else begin
						ratio_q <= rp1;
						state_q <= S_MUL_BASE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		in_ready  = (state_q == S_IDLE);
		res_valid = (state_q == S_DONE);
		if (found_q) begin
			res.best_divisor    = DIV_OUT_W'(best_sbr_q);
			res.best_oversample = OSR_OUT_W'(best_ratio_q);
			res.rate_error      = (best_err_q > CLK_W'(ERR_SAT)) ? ERR_SAT
			                                                     : best_err_q[ERR_W-1:0];
			res.found           = 1'b1;
		end else begin
			res = '0;
		end
	end

endmodule
